[rtl/rk4b_pkg.sv]
// Package: shared types, constants, micro-program and arithmetic helpers for the RK4 step block.
`default_nettype none
package rk4b_pkg;

	localparam int DataW = 32;
	localparam int FracW = 24;
	localparam int LamW  = 28;
	localparam int StepW = 24;
	localparam int TimeW = 31;
	localparam int CfgW  = 28;
	localparam int PcW   = 6;
	localparam int DivW  = DataW + FracW;
	localparam int DivCntW = 6;

	localparam logic signed [DataW-1:0] PosMax = {1'b0, {(DataW-1){1'b1}}};
	localparam logic signed [DataW-1:0] NegMin = {1'b1, {(DataW-1){1'b0}}};
	localparam logic signed [DataW-1:0] OneFix = DataW'(1) << FracW;
	// ceil(2^34 / 6): exact divide-by-six for 32-bit magnitudes after >> 34
	localparam logic [DataW-1:0] RecipSix = 32'hAAAA_AAAB;
	localparam int RecipShift = 34;

	localparam logic CfgLambda = 1'b0;
	localparam logic CfgStep   = 1'b1;

	typedef enum logic [2:0] {
		OP_ADD, OP_ADDH, OP_NEG, OP_MUL, OP_DIV6, OP_DIV, OP_END
	} op_t;

	typedef enum logic [4:0] {
		R_D, R_V, R_T, R_T2, R_T4, R_H, R_HH, R_LAM, R_L2, R_MD, R_MV,
		R_K1D, R_K1V, R_K2D, R_K2V, R_K3D, R_K3V, R_K4D, R_K4V, R_X, R_Y, R_ZERO
	} reg_sel_t;

	typedef struct packed {
		op_t      op;
		reg_sel_t dst;
		reg_sel_t sa;
		reg_sel_t sb;
	} uop_t;

	typedef struct packed {
		logic signed [DataW-1:0] val;
		logic                    sat;
	} sres_t;

	function automatic uop_t mk(op_t op, reg_sel_t dst, reg_sel_t sa, reg_sel_t sb);
		uop_t u;
		u.op = op; u.dst = dst; u.sa = sa; u.sb = sb;
		return u;
	endfunction

	// one micro-op per entry; divisor time is never zero once the sequence runs
	function automatic uop_t prog(logic [PcW-1:0] pc);
		uop_t u;
		case (pc)
			6'd0:  u = mk(OP_MUL,  R_L2,  R_LAM, R_LAM);
			6'd1:  u = mk(OP_ADD,  R_T2,  R_T,   R_HH);
			6'd2:  u = mk(OP_ADD,  R_T4,  R_T,   R_H);
			// stage 1
			6'd3:  u = mk(OP_DIV,  R_X,   R_D,   R_T);
			6'd4:  u = mk(OP_NEG,  R_X,   R_X,   R_ZERO);
			6'd5:  u = mk(OP_MUL,  R_Y,   R_L2,  R_V);
			6'd6:  u = mk(OP_NEG,  R_Y,   R_Y,   R_ZERO);
			6'd7:  u = mk(OP_ADD,  R_X,   R_X,   R_Y);
			6'd8:  u = mk(OP_MUL,  R_K1D, R_H,   R_X);
			6'd9:  u = mk(OP_MUL,  R_K1V, R_H,   R_D);
			6'd10: u = mk(OP_ADDH, R_MD,  R_D,   R_K1D);
			6'd11: u = mk(OP_ADDH, R_MV,  R_V,   R_K1V);
			// stage 2
			6'd12: u = mk(OP_DIV,  R_X,   R_MD,  R_T2);
			6'd13: u = mk(OP_NEG,  R_X,   R_X,   R_ZERO);
			6'd14: u = mk(OP_MUL,  R_Y,   R_L2,  R_MV);
			6'd15: u = mk(OP_NEG,  R_Y,   R_Y,   R_ZERO);
			6'd16: u = mk(OP_ADD,  R_X,   R_X,   R_Y);
			6'd17: u = mk(OP_MUL,  R_K2D, R_H,   R_X);
			6'd18: u = mk(OP_MUL,  R_K2V, R_H,   R_MD);
			6'd19: u = mk(OP_ADDH, R_MD,  R_D,   R_K2D);
			6'd20: u = mk(OP_ADDH, R_MV,  R_V,   R_K2V);
			// stage 3
			6'd21: u = mk(OP_DIV,  R_X,   R_MD,  R_T2);
			6'd22: u = mk(OP_NEG,  R_X,   R_X,   R_ZERO);
			6'd23: u = mk(OP_MUL,  R_Y,   R_L2,  R_MV);
			6'd24: u = mk(OP_NEG,  R_Y,   R_Y,   R_ZERO);
			6'd25: u = mk(OP_ADD,  R_X,   R_X,   R_Y);
			6'd26: u = mk(OP_MUL,  R_K3D, R_H,   R_X);
			6'd27: u = mk(OP_MUL,  R_K3V, R_H,   R_MD);
			6'd28: u = mk(OP_ADD,  R_MD,  R_D,   R_K3D);
			6'd29: u = mk(OP_ADD,  R_MV,  R_V,   R_K3V);
			// stage 4
			6'd30: u = mk(OP_DIV,  R_X,   R_MD,  R_T4);
			6'd31: u = mk(OP_NEG,  R_X,   R_X,   R_ZERO);
			6'd32: u = mk(OP_MUL,  R_Y,   R_L2,  R_MV);
			6'd33: u = mk(OP_NEG,  R_Y,   R_Y,   R_ZERO);
			6'd34: u = mk(OP_ADD,  R_X,   R_X,   R_Y);
			6'd35: u = mk(OP_MUL,  R_K4D, R_H,   R_X);
			6'd36: u = mk(OP_MUL,  R_K4V, R_H,   R_MD);
			// weighted sums, same association as the defining arithmetic
			6'd37: u = mk(OP_ADD,  R_X,   R_K2D, R_K2D);
			6'd38: u = mk(OP_ADD,  R_X,   R_K1D, R_X);
			6'd39: u = mk(OP_ADD,  R_Y,   R_K3D, R_K3D);
			6'd40: u = mk(OP_ADD,  R_Y,   R_Y,   R_K4D);
			6'd41: u = mk(OP_ADD,  R_X,   R_X,   R_Y);
			6'd42: u = mk(OP_DIV6, R_X,   R_X,   R_ZERO);
			6'd43: u = mk(OP_ADD,  R_D,   R_D,   R_X);
			6'd44: u = mk(OP_ADD,  R_Y,   R_K2V, R_K2V);
			6'd45: u = mk(OP_ADD,  R_Y,   R_K1V, R_Y);
			6'd46: u = mk(OP_ADD,  R_X,   R_K3V, R_K3V);
			6'd47: u = mk(OP_ADD,  R_X,   R_X,   R_K4V);
			6'd48: u = mk(OP_ADD,  R_X,   R_Y,   R_X);
			6'd49: u = mk(OP_DIV6, R_X,   R_X,   R_ZERO);
			6'd50: u = mk(OP_ADD,  R_V,   R_V,   R_X);
			6'd51: u = mk(OP_ADD,  R_T,   R_T4,  R_ZERO);
			default: u = mk(OP_END, R_X, R_ZERO, R_ZERO);
		endcase
		return u;
	endfunction

	function automatic sres_t sat_add(logic signed [DataW-1:0] a, logic signed [DataW-1:0] b);
		logic signed [DataW:0] s;
		sres_t r;
		s = {a[DataW-1], a} + {b[DataW-1], b};
		r.sat = 1'b0;
		if (s > $signed({1'b0, PosMax})) begin
			r.val = PosMax; r.sat = 1'b1;
		end else if (s < $signed({1'b1, NegMin})) begin
			r.val = NegMin; r.sat = 1'b1;
		end else begin
			r.val = s[DataW-1:0];
		end
		return r;
	endfunction

	function automatic sres_t sat_neg(logic signed [DataW-1:0] a);
		sres_t r;
		r.sat = (a == NegMin);
		r.val = r.sat ? PosMax : -a;
		return r;
	endfunction

	// sign a magnitude and clip to the data range
	function automatic sres_t pack_mag(logic neg, logic [63:0] m);
		sres_t r;
		if (neg) begin
			r.sat = (m > 64'({1'b0, NegMin}));
			r.val = r.sat ? NegMin : -(m[DataW-1:0]);
		end else begin
			r.sat = (m > 64'(PosMax));
			r.val = r.sat ? PosMax : m[DataW-1:0];
		end
		return r;
	endfunction

	function automatic logic [DataW-1:0] mag(logic signed [DataW-1:0] x);
		return x[DataW-1] ? DataW'(-x) : DataW'(x);
	endfunction

endpackage
`default_nettype wire

[rtl/rk4_bessel_ode_step_top.sv]
// Top level: sequenced fixed-point RK4 step of the Bessel-type system.
//
// Use: an input item with req_type 0 loads deriv/value/time from the init
// fields; req_type 1 runs one fourth-order Runge-Kutta step of size
// step_size. Every item returns one result item carrying the state after it,
// plus div_fault (stage time was zero, state kept) and sat_flag (some
// operation clipped to the Q8.24 range).
// Channels: in_valid/in_ready and out_valid/out_ready; an item moves when
// valid and ready are both high. The user writes config regs through cfg_we,
// cfg_addr, cfg_wdata only while idle; the block itself does not enforce it.
// Sequence: a load or a zero-time fault goes from the idle to the done state,
// where the result register is loaded. A step runs a 52-entry micro-program
// on one shared ALU: four divisions (56 quotient bits each in the bit-serial
// restoring divider, plus issue and writeback), 15 multiplies (13 products
// and two divide-by-six) with a writeback state, and 33 ops that write back
// directly. The divider loop takes the bulk of a step's run time.
// One item at a time: in_ready is high only when idle, so the next item is
// accepted only once the last result has gone into the output register.
// Stall: a result waits in the output register until out_ready takes it; the
// sequencer holds a newly finished result in its done state until then.
// Reset: state becomes deriv 0, value 1.0, time 16777; lambda 1.0 and step
// 16777; no result pending.
`default_nettype none
module rk4_bessel_ode_step_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic                            cfg_addr,
	input  wire logic [rk4b_pkg::CfgW-1:0]       cfg_wdata,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            req_type,
	input  wire logic signed [rk4b_pkg::DataW-1:0] init_deriv,
	input  wire logic signed [rk4b_pkg::DataW-1:0] init_value,
	input  wire logic [rk4b_pkg::TimeW-1:0]      init_time,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic signed [rk4b_pkg::DataW-1:0]    deriv_out,
	output logic signed [rk4b_pkg::DataW-1:0]    value_out,
	output logic [rk4b_pkg::TimeW-1:0]           time_out,
	output logic                                 div_fault,
	output logic                                 sat_flag
);
	import rk4b_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_RUN  = 5'b00010,
		S_DIV  = 5'b00100,
		S_WB   = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t state_q;
	logic [PcW-1:0] pc_q;
	logic [LamW-1:0]  lam_q;
	logic [StepW-1:0] step_q;
	logic sat_q, fault_q;

	// architectural state
	logic signed [DataW-1:0] d_q, v_q, t_q;
	// working registers
	logic signed [DataW-1:0] t2_q, t4_q, l2_q, md_q, mv_q, x_q, y_q;
	logic signed [DataW-1:0] k1d_q, k1v_q, k2d_q, k2v_q, k3d_q, k3v_q, k4d_q, k4v_q;

	// multiplier and divider
	logic [63:0]        prod_s1;
	logic               neg_s1;
	logic [DivW-1:0]    dnum_q;
	logic [DataW-1:0]   drem_q, dden_q;
	logic [DivCntW-1:0] dcnt_q;

	uop_t uop;
	logic signed [DataW-1:0] opa, opb, hfull;
	sres_t alu_res, wb_res;
	logic wb_en;
	logic [DataW:0] dtrial;
	logic dge;
	logic [63:0] prod_shift;

	assign hfull = DataW'({1'b0, step_q});

	function automatic logic signed [DataW-1:0] rd(reg_sel_t s);
		case (s)
			R_D:   return d_q;
			R_V:   return v_q;
			R_T:   return t_q;
			R_T2:  return t2_q;
			R_T4:  return t4_q;
			R_H:   return hfull;
			R_HH:  return hfull >>> 1;
			R_LAM: return DataW'({1'b0, lam_q});
			R_L2:  return l2_q;
			R_MD:  return md_q;
			R_MV:  return mv_q;
			R_K1D: return k1d_q;
			R_K1V: return k1v_q;
			R_K2D: return k2d_q;
			R_K2V: return k2v_q;
			R_K3D: return k3d_q;
			R_K3V: return k3v_q;
			R_K4D: return k4d_q;
			R_K4V: return k4v_q;
			R_X:   return x_q;
			R_Y:   return y_q;
			default: return '0;
		endcase
	endfunction

	assign uop = prog(pc_q);

	// operand read; re-evaluated whenever any source register changes
	always_comb begin
		opa = rd(uop.sa);
		opb = rd(uop.sb);
	end

	always_comb begin
		case (uop.op)
			OP_ADDH: alu_res = sat_add(opa, opb >>> 1);
			OP_NEG:  alu_res = sat_neg(opa);
			default: alu_res = sat_add(opa, opb);
		endcase
	end

	// writeback value: multi-cycle results, or the ALU result in the run state
	always_comb begin
		prod_shift = '0;
		case (uop.op)
			OP_DIV:  wb_res = pack_mag(neg_s1, 64'(dnum_q));
			OP_DIV6: begin
				prod_shift = prod_s1 >> RecipShift;
				wb_res.sat = 1'b0;
				wb_res.val = neg_s1 ? -(prod_shift[DataW-1:0]) : prod_shift[DataW-1:0];
			end
			default: begin
				prod_shift = prod_s1 >> FracW;
				wb_res = pack_mag(neg_s1, prod_shift);
			end
		endcase
		if (state_q == S_RUN) begin
			wb_en = (uop.op == OP_ADD) || (uop.op == OP_ADDH) || (uop.op == OP_NEG);
			wb_res = alu_res;
		end else begin
			wb_en = (state_q == S_WB);
		end
	end

	assign dtrial = {drem_q, dnum_q[DivW-1]};
	assign dge = (dtrial >= {1'b0, dden_q});
	assign in_ready = (state_q == S_IDLE);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lam_q  <= LamW'(32'd16777216);
			step_q <= StepW'(32'd16777);
		end else if (cfg_we) begin
			case (cfg_addr)
				CfgLambda: lam_q  <= cfg_wdata[LamW-1:0];
				CfgStep:   step_q <= cfg_wdata[StepW-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			pc_q      <= '0;
			sat_q     <= 1'b0;
			fault_q   <= 1'b0;
			d_q       <= '0;
			v_q       <= OneFix;
			t_q       <= DataW'(32'd16777);
			out_valid <= 1'b0;
		end else begin
			// in the done state the result register is refilled below
			if (out_valid && out_ready && state_q != S_DONE)
				out_valid <= 1'b0;
			if (wb_en) begin
				sat_q <= sat_q | wb_res.sat;
				case (uop.dst)
					R_D: d_q <= wb_res.val;
					R_V: v_q <= wb_res.val;
					R_T: t_q <= wb_res.val;
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						sat_q   <= 1'b0;
						fault_q <= 1'b0;
						pc_q    <= '0;
						if (!req_type) begin
							d_q <= init_deriv;
							v_q <= init_value;
							t_q <= DataW'({1'b0, init_time});
							state_q <= S_DONE;
						end else if (t_q == '0) begin
							// later stage times are never below t, so only t itself can be zero
							fault_q <= 1'b1;
							state_q <= S_DONE;
						end else begin
							state_q <= S_RUN;
						end
					end
				end
				S_RUN: begin
					case (uop.op)
						OP_END: state_q <= S_DONE;
						OP_MUL, OP_DIV6: state_q <= S_WB;
						OP_DIV: state_q <= S_DIV;
						default: pc_q <= pc_q + 1'b1;
					endcase
				end
				S_DIV: begin
					if (dcnt_q == '0)
						state_q <= S_WB;
				end
				S_WB: begin
					pc_q    <= pc_q + 1'b1;
					state_q <= S_RUN;
				end
				S_DONE: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// working registers, multiplier and divider datapath
	always_ff @(posedge clk) begin
		if (wb_en) begin
			case (uop.dst)
				R_T2:  t2_q  <= wb_res.val;
				R_T4:  t4_q  <= wb_res.val;
				R_L2:  l2_q  <= wb_res.val;
				R_MD:  md_q  <= wb_res.val;
				R_MV:  mv_q  <= wb_res.val;
				R_K1D: k1d_q <= wb_res.val;
				R_K1V: k1v_q <= wb_res.val;
				R_K2D: k2d_q <= wb_res.val;
				R_K2V: k2v_q <= wb_res.val;
				R_K3D: k3d_q <= wb_res.val;
				R_K3V: k3v_q <= wb_res.val;
				R_K4D: k4d_q <= wb_res.val;
				R_K4V: k4v_q <= wb_res.val;
				R_X:   x_q   <= wb_res.val;
				R_Y:   y_q   <= wb_res.val;
				default: ;
			endcase
		end
		if (state_q == S_RUN) begin
			neg_s1 <= opa[DataW-1] ^ ((uop.op != OP_DIV6) && opb[DataW-1]);
			// one shared 32x32 multiplier; divide-by-six takes the reciprocal
			prod_s1 <= 64'(mag(opa)) * 64'((uop.op == OP_DIV6) ? RecipSix : mag(opb));
			dnum_q <= {mag(opa), {FracW{1'b0}}};
			drem_q <= '0;
			dden_q <= mag(opb);
			dcnt_q <= DivCntW'(DivW - 1);
		end else if (state_q == S_DIV) begin
			// restoring division, one quotient bit a cycle
			drem_q <= dge ? DataW'(dtrial - {1'b0, dden_q}) : dtrial[DataW-1:0];
			dnum_q <= {dnum_q[DivW-2:0], dge};
			dcnt_q <= dcnt_q - 1'b1;
		end
		if (state_q == S_DONE && (!out_valid || out_ready)) begin
			deriv_out <= d_q;
			value_out <= v_q;
			time_out  <= t_q[TimeW-1:0];
			div_fault <= fault_q;
			sat_flag  <= sat_q;
		end
	end

	// checks
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted a second item while busy");

	a_fault_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && div_fault |-> !sat_flag)
		else $error("fault result reports saturation");

	a_time_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		!t_q[DataW-1])
		else $error("time went negative");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> dden_q != '0)
		else $error("division by zero time");

endmodule
`default_nettype wire
